[rtl/lrupr_pkg.sv]
// ---------------------------------------------------------------------------
// LRU page replacement - shared package
// Default sizes, fixed field widths and the item-done event that the
// sequencer hands to the top level.
// ---------------------------------------------------------------------------
package lrupr_pkg;

    // default geometry
    localparam int FRAMES_DEF    = 8;
    localparam int PAGE_BITS_DEF = 16;

    // fixed field widths
    localparam int CFG_W   = 4;
    localparam int FAULT_W = 32;

    // one-cycle pulse marking the end of an item's update pass
    typedef struct packed {
        logic valid;
        logic hit;
        logic evicted;
    } lrupr_evt_t;

endpackage

[rtl/lrupr_frame_mem.sv]
// ---------------------------------------------------------------------------
// LRU page replacement - frame memory
// One write port, one read port, read data registered.
// Each word holds a frame's page number above its recency rank.
// ---------------------------------------------------------------------------
module lrupr_frame_mem #(
    parameter int DEPTH = lrupr_pkg::FRAMES_DEF,
    parameter int WIDTH = lrupr_pkg::PAGE_BITS_DEF + $clog2(lrupr_pkg::FRAMES_DEF)
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lrupr_seq.sv]
// ---------------------------------------------------------------------------
// LRU page replacement - sequencer
// Sweeps the frame memory twice per item: a lookup pass that finds the hit,
// the first empty frame and the victim, then an update pass that ages ranks
// and writes the placed page back. Holds the per-frame valid bits.
// ---------------------------------------------------------------------------
module lrupr_seq #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  logic [PAGE_BITS-1:0]                 page_number,
    input  logic [$clog2(FRAMES+1)-1:0]          active_frames,
    output logic                                 busy,
    output lrupr_pkg::lrupr_evt_t                evt,
    output logic [$clog2(FRAMES)-1:0]            evt_slot,
    output logic [PAGE_BITS-1:0]                 evt_page,
    output logic                                 rd_en,
    output logic [$clog2(FRAMES)-1:0]            rd_addr,
    input  logic [PAGE_BITS+$clog2(FRAMES)-1:0]  rd_data,
    output logic                                 wr_en,
    output logic [$clog2(FRAMES)-1:0]            wr_addr,
    output logic [PAGE_BITS+$clog2(FRAMES)-1:0]  wr_data
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } state_t;

    state_t                 state_reg;
    logic [CW-1:0]          addr_reg;
    logic                   rd_live_reg;
    logic [IW-1:0]          rd_idx_reg;
    logic [PAGE_BITS-1:0]   page_reg;
    logic [FRAMES-1:0]      valid_reg;

    logic                   hit_found_reg, hit_found_next;
    logic [IW-1:0]          hit_slot_reg, hit_slot_next;
    logic [IW-1:0]          hit_rank_reg, hit_rank_next;
    logic                   empty_found_reg, empty_found_next;
    logic [IW-1:0]          empty_slot_reg, empty_slot_next;
    logic                   vic_found_reg, vic_found_next;
    logic [IW-1:0]          vic_slot_reg, vic_slot_next;
    logic [IW-1:0]          vic_rank_reg, vic_rank_next;
    logic [PAGE_BITS-1:0]   vic_page_reg, vic_page_next;

    lrupr_pkg::lrupr_evt_t  evt_reg;
    logic [IW-1:0]          evt_slot_reg;
    logic [PAGE_BITS-1:0]   evt_page_reg;

    logic [PAGE_BITS-1:0]   ent_page;
    logic [IW-1:0]          ent_rank;
    logic                   ent_active;
    logic                   ent_valid;
    logic                   last_entry;
    logic                   issue_more;
    logic                   accept;
    logic                   evicted;
    logic [IW-1:0]          tgt_slot;
    logic [CW-1:0]          old_rank;

    assign ent_page   = rd_data[PAGE_BITS+IW-1:IW];
    assign ent_rank   = rd_data[IW-1:0];
    assign ent_active = CW'(rd_idx_reg) < active_frames;
    assign ent_valid  = valid_reg[rd_idx_reg];
    assign last_entry = rd_live_reg && (rd_idx_reg == IW'(FRAMES - 1));
    assign issue_more = addr_reg < CW'(FRAMES);
    assign accept     = (state_reg == ST_IDLE) && start && !evt_reg.valid;
    assign busy       = (state_reg != ST_IDLE) || evt_reg.valid;

    // read issue: frame 0 on accept, then one frame a cycle
    assign rd_en   = accept || ((state_reg != ST_IDLE) && issue_more);
    assign rd_addr = (state_reg == ST_IDLE) ? '0 : addr_reg[IW-1:0];

    // lookup pass accumulation
    always_comb
    begin
        hit_found_next   = hit_found_reg;
        hit_slot_next    = hit_slot_reg;
        hit_rank_next    = hit_rank_reg;
        empty_found_next = empty_found_reg;
        empty_slot_next  = empty_slot_reg;
        vic_found_next   = vic_found_reg;
        vic_slot_next    = vic_slot_reg;
        vic_rank_next    = vic_rank_reg;
        vic_page_next    = vic_page_reg;
        if (rd_live_reg && (state_reg == ST_SCAN) && ent_active)
        begin
            if (ent_valid && (ent_page == page_reg) && !hit_found_reg)
            begin
                hit_found_next = 1'b1;
                hit_slot_next  = rd_idx_reg;
                hit_rank_next  = ent_rank;
            end
            if (!ent_valid && !empty_found_reg)
            begin
                empty_found_next = 1'b1;
                empty_slot_next  = rd_idx_reg;
            end
            // strict compare keeps the lowest frame on a rank tie
            if (!vic_found_reg || (ent_rank > vic_rank_reg))
            begin
                vic_found_next = 1'b1;
                vic_slot_next  = rd_idx_reg;
                vic_rank_next  = ent_rank;
                vic_page_next  = ent_page;
            end
        end
    end

    // placement decision, stable through the update pass
    assign evicted = !hit_found_reg && !empty_found_reg;

    always_comb
    begin
        if (hit_found_reg)
        begin
            tgt_slot = hit_slot_reg;
            old_rank = CW'(hit_rank_reg);
        end
        else if (empty_found_reg)
        begin
            tgt_slot = empty_slot_reg;
            old_rank = CW'(FRAMES);
        end
        else
        begin
            tgt_slot = vic_slot_reg;
            old_rank = CW'(vic_rank_reg);
        end
    end

    // update pass write-back
    assign wr_en   = (state_reg == ST_UPDATE) && rd_live_reg;
    assign wr_addr = rd_idx_reg;

    always_comb
    begin
        if (rd_idx_reg == tgt_slot)
        begin
            wr_data = {page_reg, {IW{1'b0}}};
        end
        else if (ent_valid && (CW'(ent_rank) < old_rank) &&
                 (ent_rank != IW'(FRAMES - 1)))
        begin
            wr_data = {ent_page, ent_rank + 1'b1};
        end
        else
        begin
            wr_data = {ent_page, ent_rank};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            addr_reg        <= '0;
            rd_live_reg     <= 1'b0;
            valid_reg       <= '0;
            evt_reg         <= '0;
            hit_found_reg   <= 1'b0;
            empty_found_reg <= 1'b0;
            vic_found_reg   <= 1'b0;
        end
        else
        begin
            evt_reg.valid <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    rd_live_reg <= 1'b0;
                    if (accept)
                    begin
                        page_reg        <= page_number;
                        addr_reg        <= CW'(1);
                        rd_live_reg     <= 1'b1;
                        rd_idx_reg      <= '0;
                        hit_found_reg   <= 1'b0;
                        empty_found_reg <= 1'b0;
                        vic_found_reg   <= 1'b0;
                        state_reg       <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    rd_live_reg <= 1'b0;
                    if (issue_more)
                    begin
                        addr_reg    <= addr_reg + 1'b1;
                        rd_live_reg <= 1'b1;
                        rd_idx_reg  <= addr_reg[IW-1:0];
                    end
                    hit_found_reg   <= hit_found_next;
                    hit_slot_reg    <= hit_slot_next;
                    hit_rank_reg    <= hit_rank_next;
                    empty_found_reg <= empty_found_next;
                    empty_slot_reg  <= empty_slot_next;
                    vic_found_reg   <= vic_found_next;
                    vic_slot_reg    <= vic_slot_next;
                    vic_rank_reg    <= vic_rank_next;
                    vic_page_reg    <= vic_page_next;
                    if (last_entry)
                    begin
                        addr_reg    <= '0;
                        rd_live_reg <= 1'b0;
                        state_reg   <= ST_UPDATE;
                    end
                end
                ST_UPDATE:
                begin
                    rd_live_reg <= 1'b0;
                    if (issue_more)
                    begin
                        addr_reg    <= addr_reg + 1'b1;
                        rd_live_reg <= 1'b1;
                        rd_idx_reg  <= addr_reg[IW-1:0];
                    end
                    if (last_entry)
                    begin
                        valid_reg[tgt_slot] <= 1'b1;
                        evt_reg.valid       <= 1'b1;
                        evt_reg.hit         <= hit_found_reg;
                        evt_reg.evicted     <= evicted;
                        evt_slot_reg        <= tgt_slot;
                        evt_page_reg        <= evicted ? vic_page_reg : '0;
                        rd_live_reg         <= 1'b0;
                        state_reg           <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign evt      = evt_reg;
    assign evt_slot = evt_slot_reg;
    assign evt_page = evt_page_reg;

endmodule

[rtl/lru_page_replacement_core.sv]
// ---------------------------------------------------------------------------
// LRU page replacement core
// Fully associative frame set with least-recently-used replacement, one
// page reference per item, one result per item.
// ---------------------------------------------------------------------------
// Using the block: raise start with a page on page_number; the item is taken
// at the clock edge where start is high and busy is low. The frame memory
// has one read port, and every item sweeps it once to look up the page and
// pick the victim, then once more to age the recency ranks and write the
// page back. The result shows for exactly one cycle with done high; there
// is no way to hold it, so capture it then. busy drops in that same cycle,
// so the next item can be taken at the edge that ends it. fault_count
// holds its value between results and sticks at all ones. Write
// frames_in_use only while busy is low and no result is pending; zero acts
// as one frame, values above FRAMES as FRAMES. Frames above the active
// count keep their pages and keep aging in rank.
// ---------------------------------------------------------------------------
module lru_page_replacement_core #(
    parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
    parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // item in
    input  logic                          start,
    output logic                          busy,
    input  logic [PAGE_BITS-1:0]          page_number,
    // configuration
    input  logic                          frames_in_use_we,
    input  logic [lrupr_pkg::CFG_W-1:0]   frames_in_use,
    // result out
    output logic                          done,
    output logic                          hit,
    output logic [$clog2(FRAMES)-1:0]     frame_slot,
    output logic                          evicted_valid,
    output logic [PAGE_BITS-1:0]          evicted_page,
    output logic [lrupr_pkg::FAULT_W-1:0] fault_count
);

    localparam int IW = $clog2(FRAMES);
    localparam int CW = $clog2(FRAMES + 1);
    // config register wide enough for both the written value and FRAMES
    localparam int NW = (CW > lrupr_pkg::CFG_W) ? CW : lrupr_pkg::CFG_W;
    localparam int MW = PAGE_BITS + IW;

    logic [NW-1:0]                  cfg_reg;
    logic [CW-1:0]                  active_frames;

    logic [lrupr_pkg::FAULT_W-1:0]  faults_reg;
    logic                           done_reg;
    logic                           hit_reg;
    logic [IW-1:0]                  slot_reg;
    logic                           ev_valid_reg;
    logic [PAGE_BITS-1:0]           ev_page_reg;

    lrupr_pkg::lrupr_evt_t          evt;
    logic [IW-1:0]                  evt_slot;
    logic [PAGE_BITS-1:0]           evt_page;

    logic                           rd_en;
    logic [IW-1:0]                  rd_addr;
    logic [MW-1:0]                  rd_data;
    logic                           wr_en;
    logic [IW-1:0]                  wr_addr;
    logic [MW-1:0]                  wr_data;

    // clamp the active frame count into 1..FRAMES
    always_comb
    begin
        if (cfg_reg == '0)
        begin
            active_frames = CW'(1);
        end
        else if (cfg_reg > NW'(FRAMES))
        begin
            active_frames = CW'(FRAMES);
        end
        else
        begin
            active_frames = cfg_reg[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= NW'(FRAMES);
        end
        else if (frames_in_use_we)
        begin
            cfg_reg <= NW'(frames_in_use);
        end
    end

    // register the result for its one-cycle window and count faults
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg   <= 1'b0;
            faults_reg <= '0;
        end
        else
        begin
            done_reg <= evt.valid;
            if (evt.valid && !evt.hit && (faults_reg != '1))
            begin
                faults_reg <= faults_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid)
        begin
            hit_reg      <= evt.hit;
            slot_reg     <= evt_slot;
            ev_valid_reg <= evt.evicted;
            ev_page_reg  <= evt_page;
        end
    end

    lrupr_seq #(
        .FRAMES    (FRAMES),
        .PAGE_BITS (PAGE_BITS)
    ) u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .page_number   (page_number),
        .active_frames (active_frames),
        .busy          (busy),
        .evt           (evt),
        .evt_slot      (evt_slot),
        .evt_page      (evt_page),
        .rd_en         (rd_en),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    lrupr_frame_mem #(
        .DEPTH (FRAMES),
        .WIDTH (MW)
    ) u_frame_mem (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    assign done          = done_reg;
    assign hit           = hit_reg;
    assign frame_slot    = slot_reg;
    assign evicted_valid = ev_valid_reg;
    assign evicted_page  = ev_page_reg;
    assign fault_count   = faults_reg;

endmodule
